[hdl/ibfp_pkg.sv]
// Package: shared types and constants of the IMU burst frame parser.
`timescale 1ns / 1ps
package ibfp_pkg;

   localparam int POS_W        = 6;
   localparam int MOTION_WORDS = 6;

   localparam logic [7:0] SYNC_FIRST  = 8'h41;
   localparam logic [7:0] SYNC_SECOND = 8'h7A;
   localparam logic [7:0] SYNC_THIRD  = 8'h30;

   // payload byte windows: [0,SEQ_END) seq, [SEQ_END,STAMP_END) stamp, then motion
   localparam logic [POS_W-1:0] SEQ_END    = 6'd2;
   localparam logic [POS_W-1:0] STAMP_END  = 6'd10;
   localparam logic [POS_W-1:0] MOTION_END = 6'd34;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_GOT1 = 2'd1,
      PH_GOT2 = 2'd2,
      PH_DATA = 2'd3
   } phase_type;

   typedef struct packed {
      logic             valid;
      logic [POS_W-1:0] pos;
      logic [7:0]       data;
   } take_type;

   typedef struct packed {
      logic [15:0]                   seq;
      logic [63:0]                   stamp;
      logic [MOTION_WORDS-1:0][31:0] motion;
   } frame_type;

endpackage

[hdl/ibfp_field_collect.sv]
// Field collector: byte shift registers for the sequence, timestamp and motion words.
`timescale 1ns / 1ps
module ibfp_field_collect
   import ibfp_pkg::*;
(
   input  logic      clock,
   input  take_type  take,
   output frame_type frame_next
);

   logic [15:0]                   seq_ff, seq_in;
   logic [63:0]                   stamp_ff, stamp_in;
   logic [MOTION_WORDS-1:0][31:0] motion_ff, motion_in;
   logic [POS_W-1:0]              offset;
   logic [2:0]                    word_idx;
   logic                          in_motion;

   assign offset    = take.pos - STAMP_END;
   assign word_idx  = offset[4:2];
   assign in_motion = (take.pos >= STAMP_END) && (take.pos < MOTION_END);

   always_comb begin
      seq_in    = seq_ff;
      stamp_in  = stamp_ff;
      motion_in = motion_ff;
      if (take.valid) begin
         if (take.pos < SEQ_END) begin
            seq_in = {seq_ff[7:0], take.data};
         end else if (take.pos < STAMP_END) begin
            stamp_in = {stamp_ff[55:0], take.data};
         end
         for (int k = 0; k < MOTION_WORDS; k++) begin
            if (in_motion && (word_idx == 3'(k))) begin
               motion_in[k] = {motion_ff[k][23:0], take.data};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      seq_ff    <= seq_in;
      stamp_ff  <= stamp_in;
      motion_ff <= motion_in;
   end

   // the frame is emitted on the last byte, so hand out the updated values
   assign frame_next.seq    = seq_in;
   assign frame_next.stamp  = stamp_in;
   assign frame_next.motion = motion_in;

endmodule

[hdl/imu_burst_frame_parser.sv]
// Top level: sync hunt, payload counting and the frame output register.
// The frame output is registered: a frame appears on rsp_ in the cycle after its last payload word is accepted.
// Throughput: one word per cycle unless req_stall holds it; a frame takes 3 sync words plus PAYLOAD_BYTES words.
// req_stall rises only at the last payload position while a frame still waits.
// Reset (synchronous, active high) returns to the sync hunt and empties the output.
`timescale 1ns / 1ps
module imu_burst_frame_parser
   import ibfp_pkg::*;
#(
   parameter int PAYLOAD_BYTES = 34
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_frame_seq,
   output logic [63:0]        rsp_stamp_bits,
   output logic signed [31:0] rsp_accel_x_raw,
   output logic signed [31:0] rsp_accel_y_raw,
   output logic signed [31:0] rsp_accel_z_raw,
   output logic signed [31:0] rsp_rate_x_raw,
   output logic signed [31:0] rsp_rate_y_raw,
   output logic signed [31:0] rsp_rate_z_raw
);

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(PAYLOAD_BYTES - 1);

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   frame_type        frame_ff, frame_in;
   frame_type        frame_next;
   take_type         take;
   logic             accept;
   logic             last_byte;
   logic             fire;
   logic             take_en;

   assign last_byte = (phase_ff == PH_DATA) && (pos_ff == LAST_POS);
   // hold the last payload word while the previous frame has not been taken
   assign req_stall = last_byte && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // next state
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               phase_in = (req_rx_byte == SYNC_FIRST) ? PH_GOT1 : PH_HUNT;
            end
            PH_GOT1: begin
               if (req_rx_byte == SYNC_SECOND) begin
                  phase_in = PH_GOT2;
               end else begin
                  phase_in = (req_rx_byte == SYNC_FIRST) ? PH_GOT1 : PH_HUNT;
               end
            end
            PH_GOT2: begin
               if (req_rx_byte == SYNC_THIRD) begin
                  phase_in = PH_DATA;
                  pos_in   = '0;
               end else begin
                  phase_in = (req_rx_byte == SYNC_FIRST) ? PH_GOT1 : PH_HUNT;
               end
            end
            PH_DATA: begin
               if (last_byte) begin
                  phase_in = PH_HUNT;
                  pos_in   = '0;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
            default: begin
               phase_in = PH_HUNT;
               pos_in   = '0;
            end
         endcase
      end
   end

   // outputs of the state machine
   always_comb begin
      take_en = 1'b0;
      fire    = 1'b0;
      unique case (phase_ff)
         PH_DATA: begin
            take_en = accept;
            fire    = accept && last_byte;
         end
         default: begin
            take_en = 1'b0;
            fire    = 1'b0;
         end
      endcase
   end

   assign take.valid = take_en;
   assign take.pos   = pos_ff;
   assign take.data  = req_rx_byte;

   ibfp_field_collect u_collect (
      .clock      (clock),
      .take       (take),
      .frame_next (frame_next)
   );

   assign rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);
   assign frame_in     = fire ? frame_next : frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_seq   = frame_ff.seq;
   assign rsp_stamp_bits  = frame_ff.stamp;
   assign rsp_accel_x_raw = frame_ff.motion[0];
   assign rsp_accel_y_raw = frame_ff.motion[1];
   assign rsp_accel_z_raw = frame_ff.motion[2];
   assign rsp_rate_x_raw  = frame_ff.motion[3];
   assign rsp_rate_y_raw  = frame_ff.motion[4];
   assign rsp_rate_z_raw  = frame_ff.motion[5];

   a_pos_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_DATA) |-> (pos_ff == '0))
      else $error("payload position not cleared outside payload");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (pos_ff <= LAST_POS))
      else $error("payload position beyond frame length");

   a_fire_valid: assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_valid && (phase_ff == PH_HUNT)))
      else $error("frame completion did not load output and restart hunt");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !fire)
      else $error("pending frame overwritten");

endmodule

[tb/imu_burst_frame_parser_test.sv]
// Testbench: byte stream deframer checked against its own frame predictor.
`timescale 1ns / 1ps
module imu_burst_frame_parser_test
   import ibfp_pkg::*;
();

   localparam int PAYLOAD_LEN    = 34;
   localparam int STUCK_LIMIT    = 4000;
   localparam int TAIL_CYCLES    = 8;
   localparam int REPORT_LIMIT   = 10;
   localparam int RANDOM_BYTES   = 1100;
   localparam int RANDOM_FRAMES  = 16;
   localparam int BYTES_PER_WORD = 4;

   typedef enum logic [1:0] {
      PL_NONE,
      PL_FILL,
      PL_RAMP,
      PL_HEAD
   } payload_kind_type;

   typedef enum logic [1:0] {
      SINK_OPEN,
      SINK_COIN,
      SINK_HOLD,
      SINK_SPARSE
   } sink_kind_type;

   // one directed sequence: lead bytes (right-justified), then an optional payload
   typedef struct packed {
      logic [63:0]      lead;
      int               lead_len;
      payload_kind_type payload;
      logic [7:0]       fill;
      bit               has_gold;
      frame_type        gold;
   } drill_row_type;

   typedef struct packed {
      logic [7:0] data;
      bit         has_gold;
      frame_type  gold;
   } tx_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [15:0]        rsp_frame_seq;
   logic [63:0]        rsp_stamp_bits;
   logic signed [31:0] rsp_accel_x_raw;
   logic signed [31:0] rsp_accel_y_raw;
   logic signed [31:0] rsp_accel_z_raw;
   logic signed [31:0] rsp_rate_x_raw;
   logic signed [31:0] rsp_rate_y_raw;
   logic signed [31:0] rsp_rate_z_raw;

   // predictor state
   phase_type                     hunt_state;
   logic [POS_W-1:0]              take_count;
   logic [15:0]                   seq_acc;
   logic [63:0]                   stamp_acc;
   logic [MOTION_WORDS-1:0][31:0] motion_acc;

   tx_word_type   tx_words[$];
   frame_type     frames_due[$];
   int            next_idx;
   int            pres_idx;
   int            burst_left;
   int            gap_left;
   int            mismatches = 0;
   int            stuck_cycles;
   sink_kind_type sink_mode;
   int            sink_left;
   int            sink_tick;

   drill_row_type drills [0:6] = '{
      '{64'h00FF7A30, 4, PL_NONE, 8'h00, 1'b0, '0},
      '{64'h417A30, 3, PL_FILL, 8'h00, 1'b1, '0},
      '{64'h41417A30, 4, PL_FILL, 8'hFF, 1'b1, '1},
      '{64'h417A417A30, 5, PL_HEAD, 8'h80, 1'b1,
        {16'h8000, 64'h8000_0000_0000_0000, {6{32'h8000_0000}}}},
      '{64'h4130417A00417A30, 8, PL_HEAD, 8'h7F, 1'b1,
        {16'h7FFF, 64'h7FFF_FFFF_FFFF_FFFF, {6{32'h7FFF_FFFF}}}},
      '{64'h417A7A417A30, 6, PL_RAMP, 8'h00, 1'b0, '0},
      '{64'h417A30, 3, PL_FILL, 8'h41, 1'b1, {34{8'h41}}}
   };

   imu_burst_frame_parser #(
      .PAYLOAD_BYTES(PAYLOAD_LEN)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_seq  (rsp_frame_seq),
      .rsp_stamp_bits (rsp_stamp_bits),
      .rsp_accel_x_raw(rsp_accel_x_raw),
      .rsp_accel_y_raw(rsp_accel_y_raw),
      .rsp_accel_z_raw(rsp_accel_z_raw),
      .rsp_rate_x_raw (rsp_rate_x_raw),
      .rsp_rate_y_raw (rsp_rate_y_raw),
      .rsp_rate_z_raw (rsp_rate_z_raw)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic phase_type restart_phase(input logic [7:0] b);
      return (b == SYNC_FIRST) ? PH_GOT1 : PH_HUNT;
   endfunction

   // advance the deframer by one word; return 1 with the frame when it completes
   function automatic bit parse_byte(input logic [7:0] b, output frame_type frame);
      int slot;
      frame = '0;
      case (hunt_state)
         PH_HUNT: hunt_state = restart_phase(b);
         PH_GOT1: hunt_state = (b == SYNC_SECOND) ? PH_GOT2 : restart_phase(b);
         PH_GOT2: begin
            if (b == SYNC_THIRD) begin
               hunt_state = PH_DATA;
               take_count = '0;
            end else begin
               hunt_state = restart_phase(b);
            end
         end
         default: begin
            if (take_count < SEQ_END) begin
               seq_acc = {seq_acc[7:0], b};
            end else if (take_count < STAMP_END) begin
               stamp_acc = {stamp_acc[55:0], b};
            end else if (take_count < MOTION_END) begin
               slot = int'(take_count - STAMP_END) / BYTES_PER_WORD;
               motion_acc[slot] = {motion_acc[slot][23:0], b};
            end
            if (int'(take_count) + 1 < PAYLOAD_LEN) begin
               take_count = take_count + 1'b1;
            end else begin
               frame.seq    = seq_acc;
               frame.stamp  = stamp_acc;
               frame.motion = motion_acc;
               hunt_state   = PH_HUNT;
               take_count   = '0;
               return 1'b1;
            end
         end
      endcase
      return 1'b0;
   endfunction

   task automatic push_word(input logic [7:0] b, input bit has_gold, input frame_type gold);
      tx_words.push_back('{b, has_gold, gold});
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("mismatch %s: expected %h, got %h", what, want, got);
      end
   endtask

   function automatic logic [7:0] random_payload_byte();
      logic [7:0] picks [7] = '{8'h00, 8'hFF, 8'h80, 8'h7F, SYNC_FIRST, SYNC_SECOND,
                                SYNC_THIRD};
      if ($urandom_range(0, 4) == 0)
         return picks[$urandom_range(0, 6)];
      return 8'($urandom);
   endfunction

   // result check, prediction at acceptance and the bursty sender
   always @(posedge clock) begin : link_proc
      frame_type decoded;
      frame_type want;
      if (reset) begin
         req_valid   <= 1'b0;
         req_rx_byte <= '0;
         hunt_state  = PH_HUNT;
         take_count  = '0;
         seq_acc     = '0;
         stamp_acc   = '0;
         motion_acc  = '0;
         frames_due.delete();
         next_idx    = 0;
         pres_idx    = 0;
         burst_left  = 0;
         gap_left    = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (frames_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("mismatch: frame with seq %h and none expected", rsp_frame_seq);
            end else begin
               want = frames_due.pop_front();
               check_field("frame_seq", want.seq, rsp_frame_seq);
               check_field("stamp_bits", want.stamp, rsp_stamp_bits);
               check_field("accel_x_raw", want.motion[0], $unsigned(rsp_accel_x_raw));
               check_field("accel_y_raw", want.motion[1], $unsigned(rsp_accel_y_raw));
               check_field("accel_z_raw", want.motion[2], $unsigned(rsp_accel_z_raw));
               check_field("rate_x_raw", want.motion[3], $unsigned(rsp_rate_x_raw));
               check_field("rate_y_raw", want.motion[4], $unsigned(rsp_rate_y_raw));
               check_field("rate_z_raw", want.motion[5], $unsigned(rsp_rate_z_raw));
            end
         end
         if (req_valid && !req_stall) begin
            if (parse_byte(tx_words[pres_idx].data, decoded))
               frames_due.push_back(tx_words[pres_idx].has_gold ?
                                    tx_words[pres_idx].gold : decoded);
         end
         // hold the word while stalled; otherwise idle out the gap or present the next
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (next_idx < tx_words.size()) begin
               req_valid   <= 1'b1;
               req_rx_byte <= tx_words[next_idx].data;
               pres_idx = next_idx;
               next_idx++;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 64);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern: windows of open, coin-flip, long holds and sparse stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         sink_mode = SINK_OPEN;
         sink_left = 0;
         sink_tick = 0;
      end else begin
         if (sink_left == 0) begin
            sink_mode = sink_kind_type'($urandom_range(0, 3));
            sink_left = $urandom_range(20, 150);
         end else begin
            sink_left--;
         end
         sink_tick++;
         case (sink_mode)
            SINK_OPEN:   rsp_stall <= 1'b0;
            SINK_COIN:   rsp_stall <= 1'($urandom_range(0, 1));
            SINK_HOLD:   rsp_stall <= (sink_tick % 40) < 30;
            default:     rsp_stall <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      int         wf_bytes;
      int         wf_frames;
      int         pick;
      int         extra;
      bit         head;
      logic [7:0] b;
      wf_bytes  = 0;
      wf_frames = 0;

      // directed sequences
      foreach (drills[i]) begin
         for (int k = drills[i].lead_len - 1; k >= 0; k--)
            push_word(drills[i].lead[8*k +: 8], 1'b0, '0);
         if (drills[i].payload != PL_NONE) begin
            for (int p = 0; p < PAYLOAD_LEN; p++) begin
               head = (p == 0) || (p == SEQ_END) ||
                      (p >= STAMP_END && (p - STAMP_END) % BYTES_PER_WORD == 0);
               case (drills[i].payload)
                  PL_FILL: b = drills[i].fill;
                  PL_RAMP: b = 8'(p * 29 + 3);
                  default: b = head ? drills[i].fill : drills[i].fill ^ 8'h80;
               endcase
               push_word(b, drills[i].has_gold && p == PAYLOAD_LEN - 1, drills[i].gold);
            end
         end
      end

      // random part: mostly well-formed frames, some broken sync and noise
      wf_bytes = tx_words.size();
      while (wf_bytes < RANDOM_BYTES || wf_frames < RANDOM_FRAMES) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            repeat (extra) push_word(SYNC_FIRST, 1'b0, '0);
            push_word(SYNC_FIRST, 1'b0, '0);
            push_word(SYNC_SECOND, 1'b0, '0);
            push_word(SYNC_THIRD, 1'b0, '0);
            for (int p = 0; p < PAYLOAD_LEN; p++)
               push_word(random_payload_byte(), 1'b0, '0);
            wf_bytes += extra + 3 + PAYLOAD_LEN;
            wf_frames++;
         end else if (pick < 85) begin
            push_word(SYNC_FIRST, 1'b0, '0);
            wf_bytes += 2;
            if ($urandom_range(0, 1)) begin
               push_word(SYNC_SECOND, 1'b0, '0);
               wf_bytes++;
            end
            push_word(random_payload_byte(), 1'b0, '0);
         end else begin
            extra = $urandom_range(1, 6);
            repeat (extra) push_word(8'($urandom), 1'b0, '0);
            wf_bytes += extra;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // drain: sample away from the active edge
      @(negedge clock);
      while (next_idx < tx_words.size() || req_valid || frames_due.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
